>>> hdl/slt_pkg.sv
// Shared constants, codes and beat types of the sorted list table.
package slt_pkg;

    // Table size and the widths that follow from it.
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the request and response beats.
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;

    // Request kinds.
    localparam logic [KIND_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [KIND_W-1:0] OP_DELETE  = 3'd1;
    localparam logic [KIND_W-1:0] OP_SEARCH  = 3'd2;
    localparam logic [KIND_W-1:0] OP_COUNT   = 3'd3;
    localparam logic [KIND_W-1:0] OP_REVERSE = 3'd4;
    localparam logic [KIND_W-1:0] OP_CLEAR   = 3'd5;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    entry_count;
    } rsp_t;

    // Result of the shared comparator.
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

endpackage

>>> hdl/slt_cmp.sv
// Shared signed comparator used by every scan over the table.
module slt_cmp
    import slt_pkg::*;
(
    input  logic signed [VALUE_W-1:0] lhs,
    input  logic signed [VALUE_W-1:0] rhs,
    output cmp_res_t                  res
);

    // Equality and signed less-than of the stored entry against the operand.
    assign res.eq = (lhs == rhs);
    assign res.lt = (lhs < rhs);

endmodule

>>> hdl/sorted_list_table_top.sv
// Top level of the sorted list table: sequencer, entry store and beat registers.
//
//  channel | direction | handshake          | beat
//  s_      | in        | s_valid / s_ready  | req_t: kind, value
//  m_      | out       | m_valid / m_ready  | rsp_t: status, position, entry_count
//
// One request is worked at a time; s_ready is high only while the sequencer is idle.
// Insert, delete and search scan the entries, insert and delete then shift them, reverse
// swaps pairs from both ends, and count and clear leave the store alone. The entry store,
// with one write port and one registered read port, is scanned one entry per cycle.
// A finished response waits in the output register while the next request is accepted.
// Synchronous active-low reset empties the table; entry contents are not cleared.
module sorted_list_table_top
    import slt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_MOVE  = 4'd2;
    localparam logic [3:0] S_REV_A = 4'd3;
    localparam logic [3:0] S_REV_B = 4'd4;
    localparam logic [3:0] S_REV_C = 4'd5;
    localparam logic [3:0] S_REV_D = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0]                state_reg, state_next;
    logic [KIND_W-1:0]         kind_reg, kind_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]          occ_reg, occ_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic                      pend_reg, pend_next;
    logic [CNT_W-1:0]          cur_reg, cur_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic [ADDR_W-1:0]         dst_reg, dst_next;
    logic [CNT_W-1:0]          p_reg, p_next;
    logic [ADDR_W-1:0]         lo_reg, lo_next;
    logic [ADDR_W-1:0]         hi_reg, hi_next;
    logic signed [VALUE_W-1:0] tmp_reg, tmp_next;
    logic [STATUS_W-1:0]       st_reg, st_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic                      m_valid_reg, m_valid_next;
    rsp_t                      m_data_reg, m_data_next;

    // Entry store and its port controls.
    logic signed [VALUE_W-1:0] mem [CAPACITY];
    logic signed [VALUE_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]         raddr;
    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic signed [VALUE_W-1:0] wdata;

    cmp_res_t                  cmp;
    logic                      hit;
    logic                      load_out;

    // One comparator serves every scan step.
    slt_cmp u_cmp (
        .lhs (rdata_reg),
        .rhs (value_reg),
        .res (cmp)
    );

    // A scan hit: insert stops at the first entry not less than the value,
    // delete and search at the first equal entry.
    assign hit = pend_reg && ((kind_reg == OP_INSERT) ? !cmp.lt : cmp.eq);

    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // Sequencer next-state logic.
    always_comb begin
        logic [CNT_W-1:0] found_pos;

        state_next = state_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        occ_next   = occ_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        cur_next   = cur_reg;
        rem_next   = rem_reg;
        dst_next   = dst_reg;
        p_next     = p_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        tmp_next   = tmp_reg;
        st_next    = st_reg;
        pos_next   = pos_reg;
        raddr      = '0;
        we         = 1'b0;
        waddr      = '0;
        wdata      = rdata_reg;
        found_pos  = hit ? (idx_reg - CNT_W'(1)) : idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_data.kind;
                    value_next = s_data.value;
                    st_next    = ST_OK;
                    pos_next   = '0;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                    unique case (s_data.kind)
                        OP_INSERT: begin
                            if (occ_reg == CNT_W'(CAPACITY)) begin
                                st_next = ST_FULL;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_DELETE: begin
                            if (occ_reg == '0) begin
                                st_next = ST_EMPTY;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_SEARCH: begin
                            state_next = S_SCAN;
                        end
                        OP_REVERSE: begin
                            if (occ_reg > CNT_W'(1)) begin
                                lo_next    = '0;
                                hi_next    = ADDR_W'(occ_reg - CNT_W'(1));
                                state_next = S_REV_A;
                            end
                        end
                        OP_CLEAR: begin
                            occ_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Walk from the head, one read issued per cycle, compare one behind.
            S_SCAN: begin
                if (hit || (idx_reg == occ_reg)) begin
                    pend_next = 1'b0;
                    unique case (kind_reg)
                        OP_INSERT: begin
                            p_next     = found_pos;
                            pos_next   = POS_W'(found_pos + CNT_W'(1));
                            rem_next   = occ_reg - found_pos;
                            cur_next   = occ_reg - CNT_W'(1);
                            state_next = S_MOVE;
                        end
                        OP_DELETE: begin
                            if (hit) begin
                                p_next     = found_pos;
                                rem_next   = occ_reg - found_pos - CNT_W'(1);
                                cur_next   = found_pos + CNT_W'(1);
                                state_next = S_MOVE;
                            end else begin
                                st_next    = ST_NOT_FOUND;
                                state_next = S_DONE;
                            end
                        end
                        default: begin
                            if (hit) begin
                                pos_next = POS_W'(found_pos + CNT_W'(1));
                            end else begin
                                st_next = ST_NOT_FOUND;
                            end
                            state_next = S_DONE;
                        end
                    endcase
                end else begin
                    raddr     = idx_reg[ADDR_W-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
            end

            // Shift entries one slot: toward the tail for insert, toward the head
            // for delete. Each read lands at its destination in the next cycle.
            S_MOVE: begin
                if (pend_reg) begin
                    we    = 1'b1;
                    waddr = dst_reg;
                    wdata = rdata_reg;
                end
                if (rem_reg != '0) begin
                    raddr     = cur_reg[ADDR_W-1:0];
                    rem_next  = rem_reg - CNT_W'(1);
                    pend_next = 1'b1;
                    if (kind_reg == OP_INSERT) begin
                        dst_next = ADDR_W'(cur_reg + CNT_W'(1));
                        cur_next = cur_reg - CNT_W'(1);
                    end else begin
                        dst_next = ADDR_W'(cur_reg - CNT_W'(1));
                        cur_next = cur_reg + CNT_W'(1);
                    end
                end else if (pend_reg) begin
                    pend_next = 1'b0;
                end else begin
                    if (kind_reg == OP_INSERT) begin
                        we       = 1'b1;
                        waddr    = p_reg[ADDR_W-1:0];
                        wdata    = value_reg;
                        occ_next = occ_reg + CNT_W'(1);
                    end else begin
                        occ_next = occ_reg - CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
            end

            // Reverse: read the low and high entries, then write them crossed.
            S_REV_A: begin
                raddr      = lo_reg;
                state_next = S_REV_B;
            end
            S_REV_B: begin
                raddr      = hi_reg;
                tmp_next   = rdata_reg;
                state_next = S_REV_C;
            end
            S_REV_C: begin
                we         = 1'b1;
                waddr      = lo_reg;
                wdata      = rdata_reg;
                state_next = S_REV_D;
            end
            S_REV_D: begin
                we      = 1'b1;
                waddr   = hi_reg;
                wdata   = tmp_reg;
                lo_next = lo_reg + ADDR_W'(1);
                hi_next = hi_reg - ADDR_W'(1);
                if ((lo_reg + ADDR_W'(1)) < (hi_reg - ADDR_W'(1))) begin
                    state_next = S_REV_A;
                end else begin
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register next value.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load_out) begin
            m_valid_next            = 1'b1;
            m_data_next.status      = st_reg;
            m_data_next.position    = pos_reg;
            m_data_next.entry_count = POS_W'(occ_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        rem_reg    <= rem_next;
        dst_reg    <= dst_next;
        p_reg      <= p_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        tmp_reg    <= tmp_next;
        st_reg     <= st_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
    end

    // Entry store: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // The table never holds more than its capacity.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    // An accepted request closes the input side in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after an accepted beat");

    // A pending compare always refers to an entry already read.
    a_pend_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && (state_reg == S_SCAN)) |-> (idx_reg != '0))
        else $error("scan compare without a prior read");

    // A new response is loaded only when the previous one has left.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("response changed before it was taken");
`endif

endmodule
